[design/lzrd_pkg.sv]
// Shared types and constants for the LZSS ring decoder.
`timescale 1ns / 1ps

package lzrd_pkg;

  // Kinds of work handed from the parser to the copy engine
  localparam logic [1:0] OP_NONE  = 2'd0;  // stream restart only, no output
  localparam logic [1:0] OP_LIT   = 2'd1;
  localparam logic [1:0] OP_MATCH = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_SKIP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RING_START  = 2'd1;

  localparam logic [7:0]  HEADER_SKIP_RST = 8'd16;
  localparam logic [11:0] RING_START_RST  = 12'hFEE;

  // Matches copy count+3 bytes
  localparam logic [4:0] MATCH_BIAS = 5'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  lit;      // literal byte
    logic [11:0] offset;   // match ring offset
    logic [3:0]  count;    // match count field
    logic        restart;  // stream ends after this op
  } op_t;

endpackage

[design/lzrd_front.sv]
// Parser: header skip, token flag tracking and op classification.
`timescale 1ns / 1ps

module lzrd_front (
  input  logic            clk,
  input  logic            rst,
  input  logic [7:0]      header_skip,
  input  logic            clearing,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  input  logic            end_of_stream,
  input  logic            q_full,
  output logic            q_push,
  output lzrd_pkg::op_t   q_wdata
);

  localparam logic [1:0] PH_FLAG  = 2'd0;
  localparam logic [1:0] PH_LIT   = 2'd1;
  localparam logic [1:0] PH_MLOW  = 2'd2;
  localparam logic [1:0] PH_MHIGH = 2'd3;

  logic [8:0] token_flags, token_flags_next;
  logic [1:0] token_phase, token_phase_next;
  logic [7:0] match_low_byte, match_low_byte_next;
  logic [7:0] header_count, header_count_next;
  logic [8:0] flags_shift;
  logic [1:0] phase_after;
  logic       accept;

  assign in_ready = !q_full && !clearing;
  assign accept   = in_valid && in_ready;

  // Phase after a literal or match completes
  assign flags_shift = token_flags >> 1;
  assign phase_after = (flags_shift <= 9'd1) ? PH_FLAG :
                       (flags_shift[0] ? PH_LIT : PH_MLOW);

  always_comb begin
    token_flags_next    = token_flags;
    token_phase_next    = token_phase;
    match_low_byte_next = match_low_byte;
    header_count_next   = header_count;
    q_wdata.kind        = lzrd_pkg::OP_NONE;
    q_wdata.lit         = in_byte;
    q_wdata.offset      = {in_byte[7:4], match_low_byte};
    q_wdata.count       = in_byte[3:0];
    q_wdata.restart     = end_of_stream;
    q_push              = 1'b0;
    if (accept) begin
      if (header_count < header_skip) begin
        header_count_next = header_count + 8'd1;
      end else begin
        case (token_phase)
          PH_FLAG: begin
            token_flags_next = {1'b1, in_byte};
            token_phase_next = in_byte[0] ? PH_LIT : PH_MLOW;
          end
          PH_LIT: begin
            q_wdata.kind      = lzrd_pkg::OP_LIT;
            token_flags_next  = flags_shift;
            token_phase_next  = phase_after;
          end
          PH_MLOW: begin
            match_low_byte_next = in_byte;
            token_phase_next    = PH_MHIGH;
          end
          default: begin
            q_wdata.kind      = lzrd_pkg::OP_MATCH;
            token_flags_next  = flags_shift;
            token_phase_next  = phase_after;
          end
        endcase
      end
      q_push = (q_wdata.kind != lzrd_pkg::OP_NONE) || end_of_stream;
      if (end_of_stream) begin
        token_flags_next    = '0;
        token_phase_next    = PH_FLAG;
        match_low_byte_next = '0;
        header_count_next   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token_flags    <= '0;
      token_phase    <= PH_FLAG;
      match_low_byte <= '0;
      header_count   <= '0;
    end else begin
      token_flags    <= token_flags_next;
      token_phase    <= token_phase_next;
      match_low_byte <= match_low_byte_next;
      header_count   <= header_count_next;
    end
  end

endmodule

[design/lzrd_queue.sv]
// Two-entry op queue between parser and copy engine.
`timescale 1ns / 1ps

module lzrd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lzrd_pkg::op_t   wdata,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output lzrd_pkg::op_t   rdata
);

  lzrd_pkg::op_t entries [2];
  logic       wr_idx;
  logic       rd_idx;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign rdata = entries[rd_idx];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_idx] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= 1'b0;
      rd_idx <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_idx <= !wr_idx;
      end
      if (pop) begin
        rd_idx <= !rd_idx;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[design/lzrd_back.sv]
// Copy engine: history ring, match copy with forwarding, output register.
`timescale 1ns / 1ps

module lzrd_back #(
  parameter int RING_DEPTH = 4096
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [11:0]     ring_start,
  output logic            clearing,
  input  logic            q_valid,
  input  lzrd_pkg::op_t   q_rdata,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            run_last
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(RING_DEPTH - 1);

  logic [7:0] ring [RING_DEPTH];

  logic [AW-1:0] clr_addr;
  logic [AW-1:0] wp;
  logic [AW-1:0] rp;
  logic [4:0]    remain;
  logic          busy;
  logic          cur_restart;
  logic          pend;        // a byte sits in the emit stage
  logic          e_last;
  logic          fwd_valid;
  logic [7:0]    fwd_data;
  logic [7:0]    rdata;
  logic [7:0]    e_data;
  logic          can_emit;
  logic          emit_fire;
  logic          issue;
  logic          done;
  logic          ring_we;
  logic [AW-1:0] ring_waddr;
  logic [7:0]    ring_wdata;
  logic [AW-1:0] start_ptr;

  assign start_ptr = AW'(ring_start);
  assign e_data    = fwd_valid ? fwd_data : rdata;
  assign can_emit  = !out_valid || out_ready;
  assign emit_fire = pend && can_emit;
  assign issue     = busy && (remain != 5'd0) && (!pend || emit_fire);
  assign done      = busy && (remain == 5'd0) && (!pend || emit_fire);
  assign q_pop     = !busy && q_valid && !clearing;

  assign ring_we    = clearing || emit_fire;
  assign ring_waddr = clearing ? clr_addr : wp;
  assign ring_wdata = clearing ? 8'd0 : e_data;

  // Single write port, single registered read port
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[ring_waddr] <= ring_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rdata <= ring[rp];
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rp          <= AW'(q_rdata.offset);
      cur_restart <= q_rdata.restart;
      fwd_data    <= q_rdata.lit;
    end else if (issue) begin
      rp <= rp + AW'(1);
      // read collides with this cycle's write: take the byte being written
      if (emit_fire) begin
        fwd_data <= e_data;
      end
    end
    if (emit_fire) begin
      out_byte <= e_data;
      run_last <= e_last;
    end
    if (issue) begin
      e_last <= (remain == 5'd1);
    end else if (q_pop) begin
      e_last <= 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_addr  <= '0;
      wp        <= AW'(lzrd_pkg::RING_START_RST);
      busy      <= 1'b0;
      remain    <= '0;
      pend      <= 1'b0;
      fwd_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + AW'(1);
        if (clr_addr == LAST_ADDR) begin
          clearing <= 1'b0;
        end
      end

      if (done && cur_restart) begin
        wp <= start_ptr;
      end else if (emit_fire) begin
        wp <= wp + AW'(1);
      end

      if (q_pop) begin
        busy <= 1'b1;
        if (q_rdata.kind == lzrd_pkg::OP_MATCH) begin
          remain    <= {1'b0, q_rdata.count} + lzrd_pkg::MATCH_BIAS;
          pend      <= 1'b0;
          fwd_valid <= 1'b0;
        end else begin
          remain    <= '0;
          pend      <= (q_rdata.kind == lzrd_pkg::OP_LIT);
          fwd_valid <= 1'b1;
        end
      end else begin
        if (done) begin
          busy <= 1'b0;
        end
        if (issue) begin
          remain    <= remain - 5'd1;
          pend      <= 1'b1;
          fwd_valid <= emit_fire && (rp == wp);
        end else if (emit_fire) begin
          pend <= 1'b0;
        end
      end

      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[design/lzss_ring_decoder.sv]
// Top level of the LZSS ring decoder: config registers, parser, queue, copy engine.
`timescale 1ns / 1ps

// LZSS decompressor with a RING_DEPTH-byte history ring (power of two, 4096 by
// default). Compressed bytes arrive one beat at a time on in_*; end_of_stream
// marks the final byte of a stream. The first header_skip bytes of each stream
// are dropped, then flag bytes select literals (bit 1) or two-byte matches
// (bit 0, 12-bit offset, count+3 bytes), bits taken LSB first. Every output
// byte is also written into the ring at a write pointer that is reloaded from
// ring_start when a stream ends; the ring keeps its contents across streams.
// Timing: after reset the ring is zeroed by a clearing pass over all RING_DEPTH
// entries during which in_ready is low (config writes are still taken). The
// parser takes one input beat per cycle as long as its two-entry op queue has
// room. The copy engine, limited by the single ring read port, takes one op at
// a time; a match gives one output beat per cycle while out_ready does not
// stall it, and an end-of-stream restart op gives no output. A match's
// read-after-write into the ring is forwarded, so overlapping copies run at
// full speed. Output is registered and out_ready stalls only the copy engine;
// the parser keeps filling the queue until it is full.
// Config (cfg_index 0 = header_skip, 1 = ring_start, others ignored) must be
// written only while the decoder is idle; ring_start is loaded into the write
// pointer when the current stream ends.
module lzss_ring_decoder #(
  parameter int RING_DEPTH = 4096
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         in_byte,
  input  logic                               end_of_stream,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [7:0]                         out_byte,
  output logic                               run_last,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lzrd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [11:0]                        cfg_data
);

  logic [7:0]    header_skip;
  logic [11:0]   ring_start;
  logic          clearing;
  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_valid;
  lzrd_pkg::op_t q_wdata;
  lzrd_pkg::op_t q_rdata;

  assign cfg_ready = 1'b1;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      header_skip <= lzrd_pkg::HEADER_SKIP_RST;
      ring_start  <= lzrd_pkg::RING_START_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lzrd_pkg::REG_HEADER_SKIP: header_skip <= cfg_data[7:0];
        lzrd_pkg::REG_RING_START:  ring_start  <= cfg_data;
        default: ;
      endcase
    end
  end

  lzrd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .header_skip   (header_skip),
    .clearing      (clearing),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .end_of_stream (end_of_stream),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_wdata       (q_wdata)
  );

  lzrd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  lzrd_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .ring_start (ring_start),
    .clearing   (clearing),
    .q_valid    (q_valid),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .run_last   (run_last)
  );

  // No input beat may be taken while the ring is being cleared
  a_no_input_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !in_ready)
    else $error("input accepted during ring clear");

  // Parser never pushes into a full queue
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("op queue overflow");

  // Copy engine pops only real ops, and never during the clear
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (q_valid && !clearing))
    else $error("op queue underflow");

endmodule
